// ===== rtl/core/plo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_pkg
// Shared types and constants for the periodic line overlay pixel block.
// ----------------------------------------------------------------------------
package plo_pkg;

    localparam int COORD_BITS_DEF      = 14;
    localparam int QUANTUM_BITS_DEF    = 16;
    localparam int DECAY_FRAC_BITS_DEF = 16;

    localparam int SIZE_W  = 15;
    localparam int DECAY_W = 17;
    localparam int MODE_W  = 3;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 17;

    localparam logic [MODE_W-1:0]  MODE_RST   = 3'd3;
    localparam logic [SIZE_W-1:0]  WIDTH_RST  = 15'd1024;
    localparam logic [SIZE_W-1:0]  HEIGHT_RST = 15'd1024;
    localparam logic [SIZE_W-1:0]  THICK_RST  = 15'd200;
    localparam logic [SIZE_W-1:0]  PERIOD_RST = 15'd0;
    localparam logic [SIZE_W-1:0]  GAP_RST    = 15'd200;
    localparam logic [DECAY_W-1:0] DECAY_RST  = 17'd0;
    localparam logic [SIZE_W-1:0]  SKIP_RST   = 15'd0;

    typedef enum logic [CFG_AW-1:0] {
        REG_MODE, REG_WIDTH, REG_HEIGHT, REG_THICK,
        REG_PERIOD, REG_GAP, REG_DECAY, REG_SKIP
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_GX, ST_GY, ST_GG, ST_INIT, ST_SRCH, ST_POW, ST_ALONG, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic gx;
        logic gy;
        logic gg;
        logic init;
        logic srch_step;
        logic pow_start;
        logic pow_step;
        logic along;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic skip_lines;
        logic srch_end;
        logic srch_hit;
        logic pow_done;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/core/plo_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_ctrl
// Sequencer: gap test, line search, decay power, length check and output hand-off.
// ----------------------------------------------------------------------------
module plo_ctrl
    import plo_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t st_reg, st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_comb begin
        st_next = st_reg;
        cmd     = '0;
        s_ready = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    st_next  = ST_GX;
                end
            end
            ST_GX: begin
                cmd.gx  = 1'b1;
                st_next = ST_GY;
            end
            ST_GY: begin
                cmd.gy  = 1'b1;
                st_next = ST_GG;
            end
            ST_GG: begin
                cmd.gg  = 1'b1;
                st_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init = 1'b1;
                st_next  = status.skip_lines ? ST_OUT : ST_SRCH;
            end
            ST_SRCH: begin
                priority if (status.srch_end) begin
                    st_next = ST_OUT;
                end else if (status.srch_hit) begin
                    cmd.pow_start = 1'b1;
                    st_next       = ST_POW;
                end else begin
                    cmd.srch_step = 1'b1;
                end
            end
            ST_POW: begin
                if (status.pow_done) begin
                    st_next = ST_ALONG;
                end else begin
                    cmd.pow_step = 1'b1;
                end
            end
            ST_ALONG: begin
                cmd.along = 1'b1;
                st_next   = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    st_next      = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_IDLE && s_valid) |=> st_reg == ST_GX)
        else $error("accepted item did not start the gap test");

    a_pow_to_along: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_POW && status.pow_done) |=> st_reg == ST_ALONG)
        else $error("power loop did not hand over to the length check");

    a_out_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_OUT && status.out_free) |=> st_reg == ST_IDLE)
        else $error("free output slot did not release the sequencer");

endmodule

// ===== rtl/core/plo_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plo_dpath
// Datapath: one shared multiplier, line search registers, result register.
// ----------------------------------------------------------------------------
module plo_dpath
    import plo_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int QUANTUM_BITS    = QUANTUM_BITS_DEF,
    parameter int DECAY_FRAC_BITS = DECAY_FRAC_BITS_DEF
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [MODE_W-1:0]       mode,
    input  logic [SIZE_W-1:0]       image_width,
    input  logic [SIZE_W-1:0]       image_height,
    input  logic [SIZE_W-1:0]       line_thickness,
    input  logic [SIZE_W-1:0]       line_period,
    input  logic [SIZE_W-1:0]       gap_radius,
    input  logic [DECAY_W-1:0]      decay_factor,
    input  logic [SIZE_W-1:0]       skip_count,
    input  logic [COORD_BITS-1:0]   s_pix_x,
    input  logic [COORD_BITS-1:0]   s_pix_y,
    input  logic [QUANTUM_BITS-1:0] s_src_red,
    input  logic [QUANTUM_BITS-1:0] s_src_green,
    input  logic [QUANTUM_BITS-1:0] s_src_blue,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic                    m_ready,
    output logic                    m_valid,
    output logic [QUANTUM_BITS-1:0] m_out_red,
    output logic [QUANTUM_BITS-1:0] m_out_green,
    output logic [QUANTUM_BITS-1:0] m_out_blue
);

    localparam int FW  = DECAY_FRAC_BITS;
    localparam int PW  = FW + 1;
    localparam int MW  = (PW > DECAY_W) ? PW : DECAY_W;
    localparam int TW  = 2 * MW + 2;
    localparam int DXW = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 1;
    localparam logic [PW-1:0] ONE = PW'(1) << FW;

    function automatic logic band_hit(input logic [SIZE_W-1:0] c,
                                      input logic [SIZE_W-1:0] d,
                                      input logic [SIZE_W-1:0] s,
                                      input logic [COORD_BITS-1:0] a);
        logic [SIZE_W+1:0] twoc, lo, hi, sum;
        twoc = {1'b0, c, 1'b0};
        sum  = twoc + (SIZE_W+2)'(d);
        hi   = sum >> 1;
        if (hi > (SIZE_W+2)'(s)) hi = (SIZE_W+2)'(s);
        if (twoc >= (SIZE_W+2)'(d)) lo = (twoc - (SIZE_W+2)'(d)) >> 1;
        else lo = '0;
        return ((SIZE_W+2)'(a) >= lo) && ((SIZE_W+2)'(a) < hi);
    endfunction

    logic                    horiz;
    logic [SIZE_W-1:0]       span, len, half;
    logic [MW-1:0]           dec;
    logic [QUANTUM_BITS-1:0] color;

    logic [COORD_BITS-1:0]   a_reg, b_reg;
    logic [QUANTUM_BITS-1:0] r_reg, g_reg, bl_reg;
    logic [DXW-2:0]          adx_reg, ady_reg;
    logic [2*MW-1:0]         sq_reg;
    logic [2*MW:0]           sum_reg;
    logic                    gapok_reg;
    logic signed [TW-1:0]    tp_reg, cp_reg, cm_reg;
    logic [SIZE_W-1:0]       i_reg, k_reg;
    logic [PW-1:0]           pw_reg;
    logic                    line_reg;
    logic                    m_valid_reg;
    logic [QUANTUM_BITS-1:0] m_red_reg, m_green_reg, m_blue_reg;

    logic signed [DXW-1:0]   dx, dy;
    logic [MW-1:0]           mul_a, mul_b;
    logic [2*MW-1:0]         prod;
    logic [PW-1:0]           u;
    logic [2*MW:0]           mhi_sum;
    logic [SIZE_W+1:0]       mlo, mhi;
    logic                    along_ok;

    assign horiz = mode[2];
    assign span  = horiz ? image_height : image_width;
    assign len   = horiz ? image_width : image_height;
    assign half  = span >> 1;
    assign dec   = (MW'(decay_factor) > MW'(ONE)) ? MW'(ONE) : MW'(decay_factor);
    assign color = mode[0] ? '1 : '0;

    assign dx = $signed(DXW'(s_pix_x)) - $signed(DXW'(image_width >> 1));
    assign dy = $signed(DXW'(s_pix_y)) - $signed(DXW'(image_height >> 1));

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        priority if (cmd.gx) begin
            mul_a = MW'(adx_reg);
            mul_b = MW'(adx_reg);
        end else if (cmd.gy) begin
            mul_a = MW'(ady_reg);
            mul_b = MW'(ady_reg);
        end else if (cmd.gg) begin
            mul_a = MW'(gap_radius);
            mul_b = MW'(gap_radius);
        end else if (cmd.init) begin
            mul_a = MW'(line_period);
            mul_b = MW'(skip_count);
        end else if (cmd.pow_step) begin
            mul_a = MW'(pw_reg);
            mul_b = dec;
        end else if (cmd.along) begin
            mul_a = MW'(u);
            mul_b = MW'(len);
        end else begin
            mul_a = '0;
        end
    end

    assign prod = mul_a * mul_b;

    assign u       = ONE - pw_reg;
    assign mhi_sum = (2*MW+1)'(prod)
                   + (((2*MW+1)'(1) << PW) - (2*MW+1)'(1));
    assign mlo     = (SIZE_W+2)'(prod >> PW);
    assign mhi     = (SIZE_W+2)'(mhi_sum >> PW);
    assign along_ok = ((SIZE_W+2)'(b_reg) >= mlo)
                   && (((SIZE_W+2)'(b_reg) + mhi) < (SIZE_W+2)'(len));

    assign status.skip_lines = !gapok_reg || (line_period == '0);
    assign status.srch_end   = tp_reg >= $signed(TW'(span));
    assign status.srch_hit   = band_hit(cp_reg[SIZE_W-1:0], line_thickness, span, a_reg)
                            || ((i_reg != '0)
                                && band_hit(cm_reg[SIZE_W-1:0], line_thickness, span,
                                            a_reg));
    assign status.pow_done   = (k_reg == i_reg) || (pw_reg == '0)
                            || ((pw_reg == ONE) && (dec == MW'(ONE)));
    assign status.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg     <= horiz ? s_pix_y : s_pix_x;
            b_reg     <= horiz ? s_pix_x : s_pix_y;
            r_reg     <= s_src_red;
            g_reg     <= s_src_green;
            bl_reg    <= s_src_blue;
            adx_reg   <= (DXW-1)'(dx[DXW-1] ? -dx : dx);
            ady_reg   <= (DXW-1)'(dy[DXW-1] ? -dy : dy);
            line_reg  <= 1'b0;
        end
        if (cmd.gx) begin
            sq_reg <= prod;
        end
        if (cmd.gy) begin
            sum_reg <= (2*MW+1)'(sq_reg) + (2*MW+1)'(prod);
        end
        if (cmd.gg) begin
            gapok_reg <= sum_reg > (2*MW+1)'(prod);
        end
        if (cmd.init) begin
            tp_reg <= $signed(TW'(prod) << 1);
            cp_reg <= $signed(TW'(half)) + $signed(TW'(prod));
            cm_reg <= $signed(TW'(half)) - $signed(TW'(prod));
            i_reg  <= skip_count;
        end
        if (cmd.srch_step) begin
            tp_reg <= tp_reg + $signed(TW'({line_period, 1'b0}));
            cp_reg <= cp_reg + $signed(TW'(line_period));
            cm_reg <= cm_reg - $signed(TW'(line_period));
            i_reg  <= i_reg + SIZE_W'(1);
        end
        if (cmd.pow_start) begin
            pw_reg <= ONE;
            k_reg  <= '0;
        end
        if (cmd.pow_step) begin
            pw_reg <= PW'(prod >> FW);
            k_reg  <= k_reg + SIZE_W'(1);
        end
        if (cmd.along) begin
            line_reg <= along_ok;
        end
        if (cmd.out_load) begin
            if (line_reg) begin
                m_red_reg   <= color;
                m_green_reg <= color;
                m_blue_reg  <= color;
            end else if (mode[1]) begin
                m_red_reg   <= r_reg;
                m_green_reg <= g_reg;
                m_blue_reg  <= bl_reg;
            end else begin
                m_red_reg   <= ~color;
                m_green_reg <= ~color;
                m_blue_reg  <= ~color;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_red   = m_red_reg;
    assign m_out_green = m_green_reg;
    assign m_out_blue  = m_blue_reg;

endmodule

// ===== rtl/core/periodic_line_overlay_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_line_overlay_pixel
// Paints periodic straight lines with a central gap over one pixel per item.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. Each item runs the gap test and a setup step;
// when the pixel lies inside the gap circle or the line period is zero, it goes
// straight to the output. Otherwise candidate line indices are tested from
// skip_count outward, up to and including the covering line, or until the frame
// span is passed. When a covering line is found, the decay multiplications follow
// (at most the index of the covering line; they end early once the power reaches
// zero or stays at one), then the length check. The item waits for the output
// register to free. All products share one multiplier. The result sits in an
// output register, so the next item is taken while it waits.
module periodic_line_overlay_pixel
    import plo_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int QUANTUM_BITS    = QUANTUM_BITS_DEF,
    parameter int DECAY_FRAC_BITS = DECAY_FRAC_BITS_DEF
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [CFG_AW-1:0]       cfg_addr,
    input  logic [CFG_DW-1:0]       cfg_wdata,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [COORD_BITS-1:0]   s_pix_x,
    input  logic [COORD_BITS-1:0]   s_pix_y,
    input  logic [QUANTUM_BITS-1:0] s_src_red,
    input  logic [QUANTUM_BITS-1:0] s_src_green,
    input  logic [QUANTUM_BITS-1:0] s_src_blue,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [QUANTUM_BITS-1:0] m_out_red,
    output logic [QUANTUM_BITS-1:0] m_out_green,
    output logic [QUANTUM_BITS-1:0] m_out_blue
);

    logic [MODE_W-1:0]  mode_reg;
    logic [SIZE_W-1:0]  width_reg, height_reg, thick_reg, period_reg, gap_reg, skip_reg;
    logic [DECAY_W-1:0] decay_reg;
    cmd_t               cmd;
    status_t            status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            thick_reg  <= THICK_RST;
            period_reg <= PERIOD_RST;
            gap_reg    <= GAP_RST;
            decay_reg  <= DECAY_RST;
            skip_reg   <= SKIP_RST;
        end else if (cfg_wen) begin
            unique case (cfg_idx_t'(cfg_addr))
                REG_MODE:   mode_reg   <= cfg_wdata[MODE_W-1:0];
                REG_WIDTH:  width_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= cfg_wdata[SIZE_W-1:0];
                REG_THICK:  thick_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_PERIOD: period_reg <= cfg_wdata[SIZE_W-1:0];
                REG_GAP:    gap_reg    <= cfg_wdata[SIZE_W-1:0];
                REG_DECAY:  decay_reg  <= cfg_wdata[DECAY_W-1:0];
                REG_SKIP:   skip_reg   <= cfg_wdata[SIZE_W-1:0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    plo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    plo_dpath #(
        .COORD_BITS      (COORD_BITS),
        .QUANTUM_BITS    (QUANTUM_BITS),
        .DECAY_FRAC_BITS (DECAY_FRAC_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mode           (mode_reg),
        .image_width    (width_reg),
        .image_height   (height_reg),
        .line_thickness (thick_reg),
        .line_period    (period_reg),
        .gap_radius     (gap_reg),
        .decay_factor   (decay_reg),
        .skip_count     (skip_reg),
        .s_pix_x        (s_pix_x),
        .s_pix_y        (s_pix_y),
        .s_src_red      (s_src_red),
        .s_src_green    (s_src_green),
        .s_src_blue     (s_src_blue),
        .cmd            (cmd),
        .status         (status),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_out_red      (m_out_red),
        .m_out_green    (m_out_green),
        .m_out_blue     (m_out_blue)
    );

endmodule
